// ===== design/rrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rrs_pkg;

	localparam int MAX_JOBS = 32;
	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = IDX_W + 1;
	localparam int TIME_W = 22;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [15:0] QUANTUM_RST = 16'd2;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] arr;
		logic [15:0] burst;
	} job_t;

	typedef struct packed {
		job_t        job;
		logic [15:0] rem;
	} ring_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ADMIT,
		ST_DISPATCH,
		ST_READMIT
	} state_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic init;
		logic admit;
		logic jump;
		logic complete;
		logic preempt;
		logic push_pre;
		logic finish;
	} cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic can_admit;
		logic arrivals_left;
		logic ring_empty;
		logic head_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/rrs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          last_job,
	input  wire rrs_pkg::sts_t sts,
	output rrs_pkg::cmd_t      cmd,
	output rrs_pkg::state_t    state,
	output logic               in_stall
);

	rrs_pkg::state_t state_q, state_n;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrs_pkg::ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	// sequence the simulation
	always_comb begin
		cmd = '0;
		state_n = state_q;
		unique case (state_q)
			rrs_pkg::ST_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_job) begin
						cmd.init = 1'b1;
						state_n = rrs_pkg::ST_ADMIT;
					end
				end
			end
			rrs_pkg::ST_ADMIT: begin
				if (sts.can_admit) begin
					cmd.admit = 1'b1;
				end else if (sts.ring_empty) begin
					if (sts.arrivals_left) begin
						cmd.jump = 1'b1;
					end else begin
						cmd.finish = 1'b1;
						state_n = rrs_pkg::ST_LOAD;
					end
				end else begin
					state_n = rrs_pkg::ST_DISPATCH;
				end
			end
			rrs_pkg::ST_DISPATCH: begin
				if (sts.head_done) begin
					if (sts.out_free) begin
						cmd.complete = 1'b1;
						state_n = rrs_pkg::ST_ADMIT;
					end
				end else begin
					cmd.preempt = 1'b1;
					state_n = rrs_pkg::ST_READMIT;
				end
			end
			rrs_pkg::ST_READMIT: begin
				if (sts.can_admit) begin
					cmd.admit = 1'b1;
				end else begin
					cmd.push_pre = 1'b1;
					state_n = rrs_pkg::ST_ADMIT;
				end
			end
			default: state_n = rrs_pkg::ST_LOAD;
		endcase
	end

	assign state = state_q;
	assign in_stall = (state_q != rrs_pkg::ST_LOAD);

endmodule
`default_nettype wire

// ===== design/rrs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrs_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rrs_pkg::cmd_t             cmd,
	output rrs_pkg::sts_t                  sts,
	input  wire logic                      cfg_we,
	input  wire logic [15:0]               cfg_wdata,
	input  wire logic [7:0]                job_id,
	input  wire logic [15:0]               job_arrival,
	input  wire logic [15:0]               job_burst,
	input  wire logic                      out_stall,
	output logic                           out_valid,
	output logic [7:0]                     done_id,
	output logic [15:0]                    done_arrival,
	output logic [15:0]                    done_burst,
	output logic [rrs_pkg::TIME_W-1:0]     completion_time,
	output logic [rrs_pkg::TIME_W-1:0]     waiting_time,
	output logic [rrs_pkg::TIME_W-1:0]     turnaround_time,
	output logic                           last_result
);

	localparam int TW = rrs_pkg::TIME_W;
	localparam int IW = rrs_pkg::IDX_W;
	localparam int CW = rrs_pkg::CNT_W;

	rrs_pkg::job_t  tab_q [rrs_pkg::MAX_JOBS];
	rrs_pkg::job_t  tab_n [rrs_pkg::MAX_JOBS];
	logic           gt    [rrs_pkg::MAX_JOBS];
	rrs_pkg::ring_t ring_q [rrs_pkg::MAX_JOBS];
	rrs_pkg::ring_t pre_q;
	rrs_pkg::ring_t head_rec, push_rec;
	rrs_pkg::job_t  new_job, nxt_job;

	logic [15:0]   quantum_q, q_eff;
	logic [CW-1:0] loaded_q, nai_q, count_q;
	logic [IW-1:0] head_q, tail;
	logic [TW-1:0] ct_q, ct_done, ct_pre;
	logic [TW:0]   sum_done, sum_pre;
	logic          push;
	logic [16:0]   atb;
	logic          out_valid_q;

	assign new_job = '{id: job_id, arr: job_arrival, burst: job_burst};
	assign q_eff = (quantum_q == 16'd0) ? 16'd1 : quantum_q;

	// hold the slice length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rrs_pkg::QUANTUM_RST;
		end else if (cfg_we) begin
			quantum_q <= cfg_wdata;
		end
	end

	// insert the new record into the sorted table, each cell looks at its neighbor
	always_comb begin
		for (int i = 0; i < rrs_pkg::MAX_JOBS; i++) begin
			gt[i] = (CW'(i) < loaded_q) &&
				({tab_q[i].arr, tab_q[i].id} > {new_job.arr, new_job.id});
		end
		for (int i = 0; i < rrs_pkg::MAX_JOBS; i++) begin
			if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				tab_n[i] = tab_q[(i > 0) ? i - 1 : 0];
			end else if (gt[i] || CW'(i) == loaded_q) begin
				tab_n[i] = new_job;
			end else begin
				tab_n[i] = tab_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && loaded_q < CW'(rrs_pkg::MAX_JOBS)) begin
			for (int i = 0; i < rrs_pkg::MAX_JOBS; i++) begin
				tab_q[i] <= tab_n[i];
			end
		end
	end

	// next arrival and ring head
	assign nxt_job = tab_q[nai_q[IW-1:0]];
	assign head_rec = ring_q[head_q];
	assign tail = head_q + count_q[IW-1:0];

	assign sts.arrivals_left = (nai_q < loaded_q);
	assign sts.can_admit = sts.arrivals_left && ({6'd0, nxt_job.arr} <= ct_q);
	assign sts.ring_empty = (count_q == '0);
	assign sts.head_done = (head_rec.rem <= q_eff);
	assign sts.out_free = !out_valid_q || !out_stall;

	// saturating time advance
	assign sum_done = {1'b0, ct_q} + (TW + 1)'(head_rec.rem);
	assign sum_pre = {1'b0, ct_q} + (TW + 1)'(q_eff);
	assign ct_done = (sum_done > {1'b0, rrs_pkg::TIME_MAX}) ?
		rrs_pkg::TIME_MAX : sum_done[TW-1:0];
	assign ct_pre = (sum_pre > {1'b0, rrs_pkg::TIME_MAX}) ?
		rrs_pkg::TIME_MAX : sum_pre[TW-1:0];

	// ring write: a new arrival or the preempted job
	assign push = cmd.admit || cmd.push_pre;
	assign push_rec = cmd.admit ? rrs_pkg::ring_t'{job: nxt_job, rem: nxt_job.burst} : pre_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ring_q[tail] <= push_rec;
		end
		if (cmd.preempt) begin
			pre_q <= '{job: head_rec.job, rem: head_rec.rem - q_eff};
		end
	end

	// advance counters and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			nai_q <= '0;
			count_q <= '0;
			head_q <= '0;
			ct_q <= '0;
		end else begin
			if (cmd.load && loaded_q < CW'(rrs_pkg::MAX_JOBS)) begin
				loaded_q <= loaded_q + CW'(1);
			end
			if (cmd.init) begin
				nai_q <= '0;
				count_q <= '0;
				head_q <= '0;
				ct_q <= '0;
			end
			if (cmd.admit) begin
				nai_q <= nai_q + CW'(1);
				count_q <= count_q + CW'(1);
			end
			if (cmd.push_pre) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.jump) begin
				ct_q <= {6'd0, nxt_job.arr};
			end
			if (cmd.complete || cmd.preempt) begin
				head_q <= head_q + IW'(1);
				count_q <= count_q - CW'(1);
			end
			if (cmd.complete) begin
				ct_q <= ct_done;
			end
			if (cmd.preempt) begin
				ct_q <= ct_pre;
			end
			if (cmd.finish) begin
				loaded_q <= '0;
				nai_q <= '0;
			end
		end
	end

	// output register
	assign atb = {1'b0, head_rec.job.arr} + {1'b0, head_rec.job.burst};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.complete) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.complete) begin
			done_id <= head_rec.job.id;
			done_arrival <= head_rec.job.arr;
			done_burst <= head_rec.job.burst;
			completion_time <= ct_done;
			waiting_time <= (ct_done >= TW'(atb)) ? ct_done - TW'(atb) : '0;
			turnaround_time <= (ct_done >= TW'(head_rec.job.arr)) ?
				ct_done - TW'(head_rec.job.arr) : '0;
			last_result <= (count_q == CW'(1)) && !sts.arrivals_left;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== design/round_robin_schedule_simulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall  | job_id, job_arrival, job_burst, last_job
// output  | out       | out_valid/out_stall| done_*, completion/waiting/turnaround, last_result
// config  | in        | cfg_we             | cfg_wdata (slice length)
// A record loads when in_valid is high while in_stall is low. After the last record
// the sequencer runs the schedule: it admits each arrived job, jumps time to the next
// arrival when the ring is empty, picks the head and dispatches it, requeues a
// preempted job after any new arrivals, and closes the set when all are done.
// Reset clears the sequencer, counters and the quantum (to 2); tables need none.
// A stalled result holds the next completion until the output register frees.
module round_robin_schedule_simulator_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            job_id,
	input  wire logic [15:0]           job_arrival,
	input  wire logic [15:0]           job_burst,
	input  wire logic                  last_job,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 done_id,
	output logic [15:0]                done_arrival,
	output logic [15:0]                done_burst,
	output logic [21:0]                completion_time,
	output logic [21:0]                waiting_time,
	output logic [21:0]                turnaround_time,
	output logic                       last_result,
	input  wire logic                  cfg_we,
	input  wire logic [15:0]           cfg_wdata
);

	rrs_pkg::cmd_t   cmd;
	rrs_pkg::sts_t   sts;
	rrs_pkg::state_t state;

	rrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_job (last_job),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state),
		.in_stall (in_stall)
	);

	rrs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.job_id          (job_id),
		.job_arrival     (job_arrival),
		.job_burst       (job_burst),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.done_id         (done_id),
		.done_arrival    (done_arrival),
		.done_burst      (done_burst),
		.completion_time (completion_time),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time),
		.last_result     (last_result)
	);

	// dispatch only from a non-empty ring
	a_dispatch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state == rrs_pkg::ST_DISPATCH |-> !sts.ring_empty)
		else $error("dispatch with empty ring");

	// ring work never overlaps: at most one command at a time past load
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.admit, cmd.jump, cmd.complete, cmd.preempt, cmd.push_pre,
			cmd.finish}))
		else $error("conflicting commands");

	// a completion never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.complete |-> (!out_valid || !out_stall))
		else $error("result overwritten");

endmodule
`default_nettype wire
